// ===== sv/mbe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbe_pkg
// Shared constants and controller/datapath handshake types for the
// escape-time engine.
// ----------------------------------------------------------------------------
package mbe_pkg;

   // Coordinate width default; coordinates carry INT_BITS integer bits
   localparam int COORD_WIDTH_DEF = 32;
   localparam int INT_BITS        = 4;

   // Iteration counter and limit register
   localparam int               CNT_WIDTH   = 16;
   localparam logic [CNT_WIDTH-1:0] LIMIT_RESET = 16'd256;

   // Commands from controller to datapath
   typedef struct packed {
      logic load;   // capture point, clear iterate and count
      logic mul;    // register the three products
      logic upd;    // escape test, then advance iterate and count
      logic emit;   // copy count into the result register
   } mbe_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic escape;      // |z|^2 > 4 on the registered products
      logic last;        // count + 1 reaches the limit
      logic limit_zero;  // limit register holds zero
   } mbe_stat_type;

endpackage

// ===== sv/mbe_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbe_if
// Valid/ready channel interfaces for the point, result and limit words.
// ----------------------------------------------------------------------------
interface mbe_req_if #(parameter int COORD_WIDTH = 32);
   logic                           valid;
   logic                           ready;
   logic signed [COORD_WIDTH-1:0] c_real;
   logic signed [COORD_WIDTH-1:0] c_imag;

   modport source (output valid, output c_real, output c_imag, input ready);
   modport sink   (input valid, input c_real, input c_imag, output ready);
endinterface

interface mbe_rsp_if #(parameter int CNT_WIDTH = 16);
   logic                 valid;
   logic                 ready;
   logic [CNT_WIDTH-1:0] iteration_count;

   modport source (output valid, output iteration_count, input ready);
   modport sink   (input valid, input iteration_count, output ready);
endinterface

interface mbe_csr_if #(parameter int CNT_WIDTH = 16);
   logic                 valid;
   logic                 ready;
   logic [CNT_WIDTH-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/mbe_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbe_ctrl
// Sequencer: accepts a point, alternates product and update cycles until
// escape or limit, then hands the count to the result register.
// ----------------------------------------------------------------------------
module mbe_ctrl
   import mbe_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   input  mbe_stat_type stat,
   output mbe_cmd_type  cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_UPD,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;

   // Take a word only between points
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   // Datapath commands
   always_comb begin
      cmd.load = accept;
      cmd.mul  = (state_ff == ST_MUL);
      cmd.upd  = (state_ff == ST_UPD);
      cmd.emit = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_ready);
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = stat.limit_zero ? ST_FINISH : ST_MUL;
            end
         end
         ST_MUL: begin
            state_in = ST_UPD;
         end
         ST_UPD: begin
            state_in = (stat.escape || stat.last) ? ST_FINISH : ST_MUL;
         end
         ST_FINISH: begin
            if (cmd.emit) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Result valid: set on emit, drop once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== sv/mbe_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbe_datapath
// Iterate registers, product stage, escape test, iteration counter, limit
// register and result register.
// ----------------------------------------------------------------------------
module mbe_datapath
   import mbe_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  mbe_cmd_type                   cmd,
   output mbe_stat_type                  stat,
   input  logic signed [COORD_WIDTH-1:0] c_real,
   input  logic signed [COORD_WIDTH-1:0] c_imag,
   input  logic                          csr_wr,
   input  logic [CNT_WIDTH-1:0]          csr_data,
   output logic [CNT_WIDTH-1:0]          iteration_count
);

   localparam int FRAC = COORD_WIDTH - INT_BITS;   // fraction bits
   localparam int MW   = COORD_WIDTH + 1;          // iterate magnitude
   localparam int PW   = 2 * MW;                   // full product
   localparam int QW   = PW - FRAC;                // truncated square
   localparam int XW   = QW + 1;                   // truncated 2xy, square sum
   localparam int SW   = COORD_WIDTH + 3;          // signed iterate
   localparam logic [XW-1:0] FOUR = XW'(1) << (COORD_WIDTH - 2);

   logic signed [COORD_WIDTH-1:0] cr_ff, ci_ff;
   logic signed [SW-1:0]          x_ff, x_in, y_ff, y_in;
   logic [QW-1:0]                 sx_ff, sy_ff;
   logic [XW-1:0]                 xy_ff;
   logic                          xy_neg_ff;
   logic [CNT_WIDTH-1:0]          cnt_ff, cnt_in;
   logic [CNT_WIDTH-1:0]          limit_ff;
   logic [CNT_WIDTH-1:0]          res_ff;

   logic signed [SW-1:0] x_neg, y_neg;
   logic [MW-1:0]        x_mag, y_mag;
   logic [PW-1:0]        prod_xx, prod_yy, prod_xy;
   logic [XW-1:0]        sq_sum;
   logic signed [SW-1:0] sx_s, sy_s, xy_mag_s, xy_s;

   // Magnitudes of the iterate; both stay below 2^COORD_WIDTH
   always_comb begin
      x_neg = -x_ff;
      y_neg = -y_ff;
      x_mag = x_ff[SW-1] ? x_neg[MW-1:0] : x_ff[MW-1:0];
      y_mag = y_ff[SW-1] ? y_neg[MW-1:0] : y_ff[MW-1:0];
   end

   // Exact products, truncated toward zero by dropping fraction bits
   assign prod_xx = PW'(x_mag) * PW'(x_mag);
   assign prod_yy = PW'(y_mag) * PW'(y_mag);
   assign prod_xy = PW'(x_mag) * PW'(y_mag);

   // Escape test on the registered squares
   assign sq_sum          = XW'(sx_ff) + XW'(sy_ff);
   assign stat.escape     = (sq_sum > FOUR);
   assign stat.last       = ((cnt_ff + CNT_WIDTH'(1)) == limit_ff);
   assign stat.limit_zero = (limit_ff == '0);

   // Next iterate: x' = x^2 - y^2 + cr, y' = 2xy + ci (valid when not escaped)
   always_comb begin
      sx_s     = $signed(SW'(sx_ff[MW-1:0]));
      sy_s     = $signed(SW'(sy_ff[MW-1:0]));
      xy_mag_s = $signed(SW'(xy_ff[MW-1:0]));
      xy_s     = xy_neg_ff ? -xy_mag_s : xy_mag_s;
      x_in     = sx_s - sy_s + SW'(cr_ff);
      y_in     = xy_s + SW'(ci_ff);
      cnt_in   = cnt_ff + CNT_WIDTH'(1);
   end

   // Point capture and iterate update
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cr_ff  <= c_real;
         ci_ff  <= c_imag;
         x_ff   <= '0;
         y_ff   <= '0;
         cnt_ff <= '0;
      end else if (cmd.upd && !stat.escape) begin
         x_ff   <= x_in;
         y_ff   <= y_in;
         cnt_ff <= cnt_in;
      end
   end

   // Product stage
   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         sx_ff     <= prod_xx[PW-1:FRAC];
         sy_ff     <= prod_yy[PW-1:FRAC];
         xy_ff     <= prod_xy[PW-1:FRAC-1];
         xy_neg_ff <= x_ff[SW-1] ^ y_ff[SW-1];
      end
   end

   // Limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else if (csr_wr) begin
         limit_ff <= csr_data;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         res_ff <= cnt_ff;
      end
   end

   assign iteration_count = res_ff;

endmodule

// ===== sv/mandelbrot_escape_time.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mandelbrot_escape_time
// Escape-time count of z = z^2 + c from z = 0 for one point per word.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one point (c_real, c_imag, signed, COORD_WIDTH - 4
//   fraction bits). rsp_ch returns one iteration_count word per point:
//   the steps done before |z|^2 > 4, or the limit if it never escapes.
//   csr_ch writes the iteration limit (reset value 256) and is always ready;
//   the user must write it only while no point is in flight (not enforced).
// Sequence:
//   Each iteration uses the shared product stage, which registers x^2,
//   y^2 and xy, and then the update step, which does the escape test and
//   advances the iterate and count. One point is in flight at a time;
//   req_ch is ready again in the cycle the result appears.
// Reset clears the sequencer and the result valid and restores the limit.
// A stalled result holds in the output register while the next point
// computes; that point waits at its end until the register is free.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time
   import mbe_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
   input logic       clock,
   input logic       reset,
   mbe_req_if.sink   req_ch,
   mbe_rsp_if.source rsp_ch,
   mbe_csr_if.sink   csr_ch
);

   mbe_cmd_type  cmd;
   mbe_stat_type stat;

   // Limit writes are always taken
   assign csr_ch.ready = 1'b1;

   mbe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   mbe_datapath #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .c_real          (req_ch.c_real),
      .c_imag          (req_ch.c_imag),
      .csr_wr          (csr_ch.valid),
      .csr_data        (csr_ch.data),
      .iteration_count (rsp_ch.iteration_count)
   );

endmodule

// ===== sv/mbe_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbe_checker
// Port-level checks on the escape-time block, bound to the top level.
// ----------------------------------------------------------------------------
module mbe_checker
   import mbe_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [CNT_WIDTH-1:0] rsp_count,
   input logic                 csr_valid,
   input logic                 csr_ready,
   input logic [CNT_WIDTH-1:0] csr_data
);

   logic [CNT_WIDTH-1:0] limit_ff;

   // Track the limit as written on the port
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         limit_ff <= csr_data;
      end
   end

   // Stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_count))
      else $error("result word changed or dropped while stalled");

   // One point in flight: input closes right after a word is taken
   a_one_point: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input ready while a point is in flight");

   // No result can appear the cycle right after a point is taken
   a_min_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !$rose(rsp_valid))
      else $error("result appeared too early");

   // Count never exceeds the configured limit
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_count <= limit_ff)
      else $error("iteration count above limit");

endmodule

bind mandelbrot_escape_time mbe_checker u_mbe_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_count (rsp_ch.iteration_count),
   .csr_valid (csr_ch.valid),
   .csr_ready (csr_ch.ready),
   .csr_data  (csr_ch.data)
);
